[hw/rtl/dtms_pkg.sv]
// ============================================================================
// dtms_pkg: shared types and constants for the devicetree memory scanner
// Token codes, parse modes, result kinds and the event record that travels
// from the structure parser to the region clipper.
// ============================================================================
`default_nettype none

package dtms_pkg;

  // Structure block token codes.
  localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
  localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
  localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
  localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
  localparam logic [31:0] TOK_END        = 32'h0000_0009;

  // First name word "memo" and the "ry" that must follow it.
  localparam logic [31:0] MEM_WORD0   = 32'h6D65_6D6F;
  localparam logic [15:0] MEM_WORD1_HI = 16'h7279;
  localparam logic [7:0]  CHAR_AT     = 8'h40;

  // Result kinds.
  localparam logic [1:0] KIND_REGION   = 2'd0;
  localparam logic [1:0] KIND_DONE     = 2'd1;
  localparam logic [1:0] KIND_NONE     = 2'd2;
  localparam logic [1:0] KIND_BADTOKEN = 2'd3;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_TOKEN   = 3'd0,
    MODE_NAME    = 3'd1,
    MODE_LEN     = 3'd2,
    MODE_NAMEOFF = 3'd3,
    MODE_SKIP    = 3'd4,
    MODE_PAIR    = 3'd5,
    MODE_HALT    = 3'd6
  } mode_t;

  // One parser event: a finished base/size pair or a status report.
  typedef struct packed {
    logic        is_pair;
    logic [1:0]  kind;
    logic [63:0] base;
    logic [63:0] len;
    logic [63:0] end_addr;
    logic [31:0] count;
  } evt_t;

endpackage

`default_nettype wire

[hw/rtl/dtms_parser.sv]
// ============================================================================
// dtms_parser: structure block token walker
// Registers each accepted word, walks the token framing, tracks node depth and
// the memory node match, assembles base/size pairs and registers one event.
// ============================================================================
`default_nettype none

module dtms_parser #(
  parameter int MAX_DEPTH = 127
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [31:0]       in_word,
  input  wire logic              in_first,
  input  wire logic [31:0]       struct_size,
  output logic                   ev_valid,
  input  wire logic              ev_ready,
  output dtms_pkg::evt_t         ev
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  // Input register.
  logic        in_v_r;
  logic [31:0] word_r;
  logic        first_r;

  // Event register.
  logic           ev_v_r;
  dtms_pkg::evt_t ev_r;

  // Parse state.
  dtms_pkg::mode_t    mode_r, mode_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               inmem_r, inmem_nxt;
  logic [1:0]         nwi_r, nwi_nxt;
  logic               nsm_r, nsm_nxt;
  logic [31:0]        bc_r, bc_nxt;
  logic [30:0]        pwl_r, pwl_nxt;
  logic [1:0]         pwi_r, pwi_nxt;
  logic [63:0]        pbase_r, pbase_nxt;
  logic [31:0]        plh_r, plh_nxt;
  logic [31:0]        pairs_r, pairs_nxt;

  logic           slot_free;
  logic           consume;
  logic           ev_v_c;
  dtms_pkg::evt_t ev_c;

  // The event slot can take a new event when empty or being drained.
  assign slot_free = !ev_v_r || ev_ready;
  assign consume   = in_v_r && slot_free;
  assign in_stall  = in_v_r && !slot_free;
  assign ev_valid  = ev_v_r;
  assign ev        = ev_r;

  // Next parse state for the word in the input register.
  always_comb begin
    dtms_pkg::mode_t    m;
    logic [DEPTH_W-1:0] d;
    logic               im;
    logic [1:0]         nwi;
    logic               nsm;
    logic [31:0]        bc;
    logic [30:0]        pwl;
    logic [1:0]         pwi;
    logic [63:0]        pb;
    logic [31:0]        plh;
    logic [31:0]        pf;
    logic [63:0]        len64;
    logic               zero_byte;
    logic               payload_done;
    m   = mode_r;
    d   = depth_r;
    im  = inmem_r;
    nwi = nwi_r;
    nsm = nsm_r;
    bc  = bc_r;
    pwl = pwl_r;
    pwi = pwi_r;
    pb  = pbase_r;
    plh = plh_r;
    pf  = pairs_r;
    // A first word clears all parse state before it is read.
    if (first_r) begin
      m   = dtms_pkg::MODE_TOKEN;
      d   = '0;
      im  = 1'b0;
      nwi = '0;
      nsm = 1'b0;
      bc  = '0;
      pwl = '0;
      pwi = '0;
      pb  = '0;
      plh = '0;
      pf  = '0;
    end
    len64        = {plh, word_r};
    zero_byte    = (word_r[31:24] == 8'd0) || (word_r[23:16] == 8'd0) ||
                   (word_r[15:8] == 8'd0) || (word_r[7:0] == 8'd0);
    payload_done = 1'b0;
    ev_v_c           = 1'b0;
    ev_c.is_pair     = 1'b0;
    ev_c.kind        = (pf != 32'd0) ? dtms_pkg::KIND_DONE : dtms_pkg::KIND_NONE;
    ev_c.base        = pb;
    ev_c.len         = len64;
    ev_c.end_addr    = pb + len64;
    ev_c.count       = pf;

    if (m == dtms_pkg::MODE_HALT) begin
      // Halted: words are dropped until the next first word.
    end else if (m == dtms_pkg::MODE_TOKEN && bc >= struct_size) begin
      ev_v_c = 1'b1;
      m      = dtms_pkg::MODE_HALT;
    end else begin
      bc = (bc >= 32'hFFFF_FFFC) ? 32'hFFFF_FFFF : bc + 32'd4;
      unique case (m)
        dtms_pkg::MODE_TOKEN: begin
          if (word_r == dtms_pkg::TOK_BEGIN_NODE) begin
            if (d < DEPTH_W'(MAX_DEPTH)) d = d + DEPTH_W'(1);
            nwi = '0;
            nsm = 1'b1;
            m   = dtms_pkg::MODE_NAME;
          end else if (word_r == dtms_pkg::TOK_END_NODE) begin
            if (d == DEPTH_W'(2)) im = 1'b0;
            if (d != '0) d = d - DEPTH_W'(1);
          end else if (word_r == dtms_pkg::TOK_PROP) begin
            m = dtms_pkg::MODE_LEN;
          end else if (word_r == dtms_pkg::TOK_NOP) begin
            m = dtms_pkg::MODE_TOKEN;
          end else if (word_r == dtms_pkg::TOK_END) begin
            ev_v_c = 1'b1;
            m      = dtms_pkg::MODE_HALT;
          end else begin
            ev_v_c    = 1'b1;
            ev_c.kind = dtms_pkg::KIND_BADTOKEN;
            m         = dtms_pkg::MODE_HALT;
          end
        end
        dtms_pkg::MODE_NAME: begin
          // Match "memory" followed by a terminator or an at sign.
          if (nwi == 2'd0) begin
            if (word_r != dtms_pkg::MEM_WORD0) nsm = 1'b0;
          end else if (nwi == 2'd1) begin
            if (word_r[31:16] != dtms_pkg::MEM_WORD1_HI ||
                (word_r[15:8] != 8'd0 && word_r[15:8] != dtms_pkg::CHAR_AT)) begin
              nsm = 1'b0;
            end
          end
          if (nwi != 2'd2) nwi = nwi + 2'd1;
          if (zero_byte) begin
            if (d == DEPTH_W'(2)) im = nsm;
            m = dtms_pkg::MODE_TOKEN;
          end
        end
        dtms_pkg::MODE_LEN: begin
          plh = word_r;
          pwl = {1'b0, word_r[31:2]} + {30'd0, |word_r[1:0]};
          m   = dtms_pkg::MODE_NAMEOFF;
        end
        dtms_pkg::MODE_NAMEOFF: begin
          if (pwl == '0) begin
            m = dtms_pkg::MODE_TOKEN;
          end else if (im && plh[31:4] != 28'd0 && plh[3:0] == 4'd0) begin
            pwi = '0;
            m   = dtms_pkg::MODE_PAIR;
          end else begin
            m = dtms_pkg::MODE_SKIP;
          end
        end
        dtms_pkg::MODE_SKIP: begin
          payload_done = 1'b1;
        end
        dtms_pkg::MODE_PAIR: begin
          case (pwi)
            2'd0: pb  = {word_r, 32'd0};
            2'd1: pb  = {pb[63:32], word_r};
            2'd2: plh = word_r;
            default: begin
              if (pf != 32'hFFFF_FFFF) pf = pf + 32'd1;
              ev_v_c       = 1'b1;
              ev_c.is_pair = 1'b1;
              ev_c.kind    = dtms_pkg::KIND_REGION;
              ev_c.count   = pf;
            end
          endcase
          pwi          = pwi + 2'd1;
          payload_done = 1'b1;
        end
        default: begin
          m = dtms_pkg::MODE_HALT;
        end
      endcase
      // One payload word has been used up.
      if (payload_done) begin
        if (pwl != '0) pwl = pwl - 31'd1;
        if (pwl == '0) m = dtms_pkg::MODE_TOKEN;
      end
    end

    mode_nxt  = m;
    depth_nxt = d;
    inmem_nxt = im;
    nwi_nxt   = nwi;
    nsm_nxt   = nsm;
    bc_nxt    = bc;
    pwl_nxt   = pwl;
    pwi_nxt   = pwi;
    pbase_nxt = pb;
    plh_nxt   = plh;
    pairs_nxt = pf;
  end

  // Input register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (consume) begin
      in_v_r <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      word_r  <= in_word;
      first_r <= in_first;
    end
  end

  // Parse state advances once per consumed word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= dtms_pkg::MODE_TOKEN;
      depth_r <= '0;
      inmem_r <= 1'b0;
      nwi_r   <= '0;
      nsm_r   <= 1'b0;
      bc_r    <= '0;
      pwl_r   <= '0;
      pwi_r   <= '0;
      pbase_r <= '0;
      plh_r   <= '0;
      pairs_r <= '0;
    end else if (consume) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      inmem_r <= inmem_nxt;
      nwi_r   <= nwi_nxt;
      nsm_r   <= nsm_nxt;
      bc_r    <= bc_nxt;
      pwl_r   <= pwl_nxt;
      pwi_r   <= pwi_nxt;
      pbase_r <= pbase_nxt;
      plh_r   <= plh_nxt;
      pairs_r <= pairs_nxt;
    end
  end

  // Event register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_v_r <= 1'b0;
    end else if (slot_free) begin
      ev_v_r <= consume && ev_v_c;
    end
    if (slot_free) begin
      ev_r <= ev_c;
    end
  end

  // Depth stays within its configured bound.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DEPTH))
    else $error("node depth above its bound");

  // Pairs always end on a whole pair, so the word index is zero outside them.
  a_pair_index: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != dtms_pkg::MODE_PAIR |-> pwi_r == 2'd0)
    else $error("pair word index left nonzero");

  // The memory node flag can only be set at depth two or below it.
  a_inmem_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inmem_r |-> depth_r >= DEPTH_W'(2))
    else $error("memory node flag set above depth two");

  // A waiting event holds until the clipper takes it.
  a_ev_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ev_v_r && !ev_ready |=> ev_v_r && $stable(ev_r))
    else $error("pending event lost or changed");

endmodule

`default_nettype wire

[hw/rtl/dtms_clip.sv]
// ============================================================================
// dtms_clip: region clipper and result register
// Clips each base/size pair against the kernel end address, drops pairs that
// lie wholly below it, and holds one result for the output channel.
// ============================================================================
`default_nettype none

module dtms_clip (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [63:0]    kern_top,
  input  wire logic           ev_valid,
  output logic                ev_ready,
  input  wire dtms_pkg::evt_t ev,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          out_kind,
  output logic [63:0]         out_mem_base,
  output logic [63:0]         out_mem_len,
  output logic [31:0]         out_region_count
);

  logic        out_v_r;
  logic [1:0]  kind_r;
  logic [63:0] base_r;
  logic [63:0] len_r;
  logic [31:0] count_r;

  logic        slot_free;
  logic        keep;
  logic [63:0] base_c;
  logic [63:0] len_c;

  assign slot_free = !out_v_r || !out_stall;
  assign ev_ready  = slot_free;

  // Pass a pair whole, trim it to start at the kernel end, or drop it.
  always_comb begin
    keep   = 1'b1;
    base_c = 64'd0;
    len_c  = 64'd0;
    if (ev.is_pair) begin
      if (kern_top <= ev.base) begin
        base_c = ev.base;
        len_c  = ev.len;
      end else if (kern_top < ev.end_addr) begin
        base_c = kern_top;
        len_c  = ev.end_addr - kern_top;
      end else begin
        keep = 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (slot_free) begin
      out_v_r <= ev_valid && keep;
    end
    if (slot_free) begin
      kind_r  <= ev.kind;
      base_r  <= base_c;
      len_r   <= len_c;
      count_r <= ev.count;
    end
  end

  assign out_valid        = out_v_r;
  assign out_kind         = kind_r;
  assign out_mem_base     = base_r;
  assign out_mem_len      = len_r;
  assign out_region_count = count_r;

endmodule

`default_nettype wire

[hw/rtl/devicetree_memory_region_scanner_core.sv]
// ============================================================================
// devicetree_memory_region_scanner_core: devicetree memory region scanner
// Walks a flattened devicetree structure block and reports usable memory
// regions above the kernel image, then a done or error status.
// ============================================================================
// The block takes one structure word per clock cycle while out_stall does
// not back up the event and result registers, and each word passes three
// registers (input, parser event, result) on its way to the result port, in
// that order. The rate is set by the token walker, which updates its parse
// state once per word; the one 64-bit end-address add sits in the walker
// stage and the clip compares and subtract in the stage after it. Only the
// last word of a base/size pair that is not wholly below the kernel, the END
// token, the size limit or an unknown token produce a result. Registers sit
// on an APB-style port: the 64-bit kernel top address at address 0 and
// struct_size at address 8, decoded on address bit 3. Write them only while
// the block is idle. There is no clearing pass after reset; a word with first
// set restarts the walk.
`default_nettype none

module devicetree_memory_region_scanner_core #(
  parameter int MAX_DEPTH = 127
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_word,
  input  wire logic        in_first,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [63:0]      out_mem_base,
  output logic [63:0]      out_mem_len,
  output logic [31:0]      out_region_count,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0] kern_top_r;
  logic [31:0] struct_size_r;
  logic        wr_en;

  logic           ev_valid;
  logic           ev_ready;
  dtms_pkg::evt_t ev;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kern_top_r    <= '0;
      struct_size_r <= '0;
    end else if (wr_en) begin
      if (paddr[3]) begin
        struct_size_r <= pwdata[31:0];
      end else begin
        kern_top_r <= pwdata;
      end
    end
  end

  // Register readback.
  assign prdata = paddr[3] ? {32'd0, struct_size_r} : kern_top_r;

  dtms_parser #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .in_first    (in_first),
    .struct_size (struct_size_r),
    .ev_valid    (ev_valid),
    .ev_ready    (ev_ready),
    .ev          (ev)
  );

  dtms_clip u_clip (
    .clk              (clk),
    .rst_n            (rst_n),
    .kern_top         (kern_top_r),
    .ev_valid         (ev_valid),
    .ev_ready         (ev_ready),
    .ev               (ev),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_mem_base     (out_mem_base),
    .out_mem_len      (out_mem_len),
    .out_region_count (out_region_count)
  );

endmodule

`default_nettype wire

[tb/tb_devicetree_memory_region_scanner_core.sv]
// ============================================================================
// tb_devicetree_memory_region_scanner_core: testbench for the memory scanner
// Feeds flattened devicetree structure blocks into the scanner and checks
// every region, done and error report against a cycle-free predictor of the
// token walk and the kernel-end clipping. A short directed list comes first,
// then random well-formed blocks with noise and damaged blocks mixed in,
// under several register settings, with random idling on both channels.
// ============================================================================
module tb_devicetree_memory_region_scanner_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH_LIMIT    = 127;
  localparam int PAIR_BYTES     = 16;
  localparam logic [3:0] REG_KTOP        = 4'h0;
  localparam logic [3:0] REG_STRUCT_SIZE = 4'h8;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 900;
  localparam int PHASE_ITEMS    = 70;
  localparam int IDLE_PCT       = 19;

  // One report of the scanner, in the order of the result ports.
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] base;
    logic [63:0] len;
    logic [31:0] count;
  } report_t;

  // Directed list: an item, or a register write done while the block is idle.
  typedef enum logic [1:0] {ROW_ITEM, ROW_KEND, ROW_SIZE} row_op_t;

  typedef struct {
    row_op_t     op;
    logic [63:0] value;
    logic        first;
    logic        typed;
    logic [1:0]  kind;
    logic [31:0] count;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_word;
  logic        in_first;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [63:0] out_mem_base;
  logic [63:0] out_mem_len;
  logic [31:0] out_region_count;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  devicetree_memory_region_scanner_core #(
    .MAX_DEPTH(DEPTH_LIMIT)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .in_first(in_first),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_mem_base(out_mem_base),
    .out_mem_len(out_mem_len),
    .out_region_count(out_region_count),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Predictor copy of the registers and of the walk state.
  logic [63:0]     kern_top_reg;
  logic [31:0]     struct_size_reg;
  dtms_pkg::mode_t walk_mode;
  logic [7:0]      depth;
  logic            mem_node;
  logic [1:0]      name_idx;
  logic            name_ok;
  logic [31:0]     byte_count;
  logic [31:0]     words_left;
  logic [1:0]      pair_idx;
  logic [63:0]     base_hold;
  logic [31:0]     len_hold;
  logic [31:0]     pair_total;

  report_t     expected_reports[$];
  dir_row_t    dir_rows[$];
  logic [31:0] blk_words[$];
  logic        blk_firsts[$];

  int fail_count = 0;
  int live_items = 0;
  int quiet_cycles = 0;
  int in_idle_pct = IDLE_PCT;
  int out_idle_pct = IDLE_PCT;
  bit hold_ask = 1'b0;
  bit hold_done = 1'b0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor of the token walk.
  // ---------------------------------------------------------------------------
  function automatic bit word_has_nul(input logic [31:0] w);
    return w[31:24] == 8'h00 || w[23:16] == 8'h00 || w[15:8] == 8'h00 || w[7:0] == 8'h00;
  endfunction

  function automatic void clear_walk();
    walk_mode  = dtms_pkg::MODE_TOKEN;
    depth      = '0;
    mem_node   = 1'b0;
    name_idx   = '0;
    name_ok    = 1'b0;
    byte_count = '0;
    words_left = '0;
    pair_idx   = '0;
    base_hold  = '0;
    len_hold   = '0;
    pair_total = '0;
  endfunction

  function automatic void post_report(input logic [1:0] kind, input logic [63:0] base,
                                      input logic [63:0] len);
    report_t rep;
    rep = {kind, base, len, pair_total};
    expected_reports.push_back(rep);
  endfunction

  function automatic void finish_walk();
    walk_mode = dtms_pkg::MODE_HALT;
    post_report(pair_total != 0 ? dtms_pkg::KIND_DONE : dtms_pkg::KIND_NONE,
                64'h0, 64'h0);
  endfunction

  function automatic void next_payload_word();
    if (words_left != 0) words_left = words_left - 1;
    if (words_left == 0) walk_mode = dtms_pkg::MODE_TOKEN;
  endfunction

  // Advances the walk by one word; taken is low when the word is ignored.
  function automatic void scan_word(input logic [31:0] w, input logic f, output bit taken);
    logic [1:0]  idx;
    logic [63:0] pair_len;
    logic [63:0] pair_end;
    if (f) clear_walk();
    taken = (walk_mode != dtms_pkg::MODE_HALT);
    if (walk_mode == dtms_pkg::MODE_HALT) return;
    // The size limit is looked at only on a token boundary.
    if (walk_mode == dtms_pkg::MODE_TOKEN && byte_count >= struct_size_reg) begin
      finish_walk();
      return;
    end
    byte_count = (byte_count <= 32'hFFFF_FFFB) ? byte_count + 32'd4 : 32'hFFFF_FFFF;
    case (walk_mode)
      dtms_pkg::MODE_TOKEN: begin
        if (w == dtms_pkg::TOK_BEGIN_NODE) begin
          if (depth < DEPTH_LIMIT) depth = depth + 1;
          name_idx  = '0;
          name_ok   = 1'b1;
          walk_mode = dtms_pkg::MODE_NAME;
        end else if (w == dtms_pkg::TOK_END_NODE) begin
          if (depth == 2) mem_node = 1'b0;
          if (depth > 0) depth = depth - 1;
        end else if (w == dtms_pkg::TOK_PROP) begin
          walk_mode = dtms_pkg::MODE_LEN;
        end else if (w == dtms_pkg::TOK_END) begin
          finish_walk();
        end else if (w != dtms_pkg::TOK_NOP) begin
          walk_mode = dtms_pkg::MODE_HALT;
          post_report(dtms_pkg::KIND_BADTOKEN, 64'h0, 64'h0);
        end
      end
      dtms_pkg::MODE_NAME: begin
        // Only "memory" and "memory@..." keep the match alive.
        if (name_idx == 0) begin
          if (w != dtms_pkg::MEM_WORD0) name_ok = 1'b0;
        end else if (name_idx == 1) begin
          if (w[31:16] != dtms_pkg::MEM_WORD1_HI ||
              (w[15:8] != 8'h00 && w[15:8] != dtms_pkg::CHAR_AT))
            name_ok = 1'b0;
        end
        if (name_idx < 2) name_idx = name_idx + 1;
        if (word_has_nul(w)) begin
          if (depth == 2) mem_node = name_ok;
          walk_mode = dtms_pkg::MODE_TOKEN;
        end
      end
      dtms_pkg::MODE_LEN: begin
        len_hold   = w;
        words_left = {2'b00, w[31:2]} + ((w[1:0] != 2'b00) ? 32'd1 : 32'd0);
        walk_mode  = dtms_pkg::MODE_NAMEOFF;
      end
      dtms_pkg::MODE_NAMEOFF: begin
        if (words_left == 0) begin
          walk_mode = dtms_pkg::MODE_TOKEN;
        end else if (mem_node && len_hold >= PAIR_BYTES && len_hold[3:0] == 4'h0) begin
          pair_idx  = '0;
          walk_mode = dtms_pkg::MODE_PAIR;
        end else begin
          walk_mode = dtms_pkg::MODE_SKIP;
        end
      end
      dtms_pkg::MODE_SKIP: next_payload_word();
      dtms_pkg::MODE_PAIR: begin
        idx = pair_idx;
        case (idx)
          2'd0: base_hold = {w, 32'h0};
          2'd1: base_hold = base_hold | {32'h0, w};
          2'd2: len_hold = w;
          default: begin
            // Clip the pair against the kernel end; the end address wraps.
            pair_len = {len_hold, w};
            pair_end = base_hold + pair_len;
            if (pair_total != 32'hFFFF_FFFF) pair_total = pair_total + 1;
            if (kern_top_reg <= base_hold)
              post_report(dtms_pkg::KIND_REGION, base_hold, pair_len);
            else if (kern_top_reg < pair_end)
              post_report(dtms_pkg::KIND_REGION, kern_top_reg, pair_end - kern_top_reg);
          end
        endcase
        pair_idx = idx + 2'd1;
        next_payload_word();
      end
      default: walk_mode = dtms_pkg::MODE_HALT;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Channel and register drivers.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] w, input logic f);
    bit took;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    in_first <= f;
    do @(posedge clk); while (in_stall);
    scan_word(w, f, took);
    if (took) live_items++;
  endtask

  // Stops the input and waits until the block has drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_KTOP) kern_top_reg = data;
    else struct_size_reg = data[31:0];
    // Leaves the port idle before the next transfer.
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Block generator.
  // ---------------------------------------------------------------------------
  function automatic void queue_word(input logic [31:0] w, input logic f = 1'b0);
    blk_words.push_back(w);
    blk_firsts.push_back(f);
  endfunction

  function automatic logic [31:0] nul_free_word();
    logic [31:0] w;
    logic [31:0] b;
    for (int i = 0; i < 4; i++) begin
      b = $urandom_range(1, 255);
      w = {w[23:0], b[7:0]};
    end
    return w;
  endfunction

  // Addresses cluster around the kernel end so that every clip case shows up.
  function automatic logic [63:0] pick_addr();
    case ($urandom_range(0, 6))
      0: return 64'h0;
      1: return '1;
      2: return kern_top_reg + $urandom_range(0, 4096);
      3: return kern_top_reg - $urandom_range(0, 4096);
      4: return {$urandom, $urandom};
      5: return {32'h0, $urandom};
      default: return kern_top_reg;
    endcase
  endfunction

  function automatic logic [63:0] pick_size();
    case ($urandom_range(0, 4))
      0: return 64'h0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return {32'h0, $urandom_range(0, 32'h0001_0000)};
    endcase
  endfunction

  function automatic void gen_name(input bit memory_like);
    logic [31:0] second;
    logic [31:0] tail;
    int lane;
    case (memory_like ? $urandom_range(0, 2) : $urandom_range(3, 5))
      0: begin
        queue_word(dtms_pkg::MEM_WORD0);
        queue_word(32'h7279_0000);
      end
      1: begin
        queue_word(dtms_pkg::MEM_WORD0);
        queue_word(32'h7279_4038);
        queue_word(32'h3030_3030);
        queue_word(32'h3030_3000);
      end
      2: begin
        // Names that come close to the memory node name.
        queue_word($urandom_range(0, 3) == 0 ? 32'h6D65_6D78 : dtms_pkg::MEM_WORD0);
        case ($urandom_range(0, 4))
          0: second = 32'h7279_4000;
          1: second = 32'h7279_7800;
          2: second = 32'h7278_0000;
          3: second = 32'h7279_0041;
          default: second = 32'h7279_4031;
        endcase
        queue_word(second);
        if (!word_has_nul(second)) queue_word(32'h0);
      end
      3: queue_word(32'h0);
      default: begin
        repeat ($urandom_range(0, 2)) queue_word(nul_free_word());
        tail = nul_free_word();
        lane = $urandom_range(0, 3);
        tail[lane*8 +: 8] = 8'h00;
        queue_word(tail);
      end
    endcase
  endfunction

  function automatic void gen_pairs(input int npairs);
    logic [63:0] b;
    logic [63:0] s;
    queue_word(dtms_pkg::TOK_PROP);
    queue_word(PAIR_BYTES * npairs);
    queue_word($urandom);
    repeat (npairs) begin
      b = pick_addr();
      s = pick_size();
      queue_word(b[63:32]);
      queue_word(b[31:0]);
      queue_word(s[63:32]);
      queue_word(s[31:0]);
    end
  endfunction

  function automatic void gen_plain_prop();
    int plen;
    queue_word(dtms_pkg::TOK_PROP);
    if ($urandom_range(0, 15) == 0) begin
      // A wild length swallows the rest of the block as payload.
      queue_word($urandom);
      queue_word($urandom);
      repeat ($urandom_range(0, 3)) queue_word($urandom);
    end else begin
      plen = $urandom_range(0, 23);
      queue_word(plen);
      queue_word($urandom);
      repeat ((plen + 3) / 4) queue_word($urandom);
    end
  endfunction

  function automatic void gen_node(input int level);
    queue_word(dtms_pkg::TOK_BEGIN_NODE);
    gen_name(level == 2 || $urandom_range(0, 3) == 0);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0, 1: gen_pairs($urandom_range(0, 3));
        2: gen_plain_prop();
        3: queue_word(dtms_pkg::TOK_NOP);
        default: begin
          if (level < 4) gen_node(level + 1);
          else queue_word(dtms_pkg::TOK_NOP);
        end
      endcase
    end
    queue_word(dtms_pkg::TOK_END_NODE);
  endfunction

  // A whole structure block, now and then damaged or followed by noise.
  function automatic void gen_block();
    int roll;
    int cut;
    blk_words.delete();
    blk_firsts.delete();
    queue_word(dtms_pkg::TOK_BEGIN_NODE, 1'b1);
    queue_word(32'h0);
    if ($urandom_range(0, 2) == 0) gen_plain_prop();
    repeat ($urandom_range(0, 3)) gen_node(2);
    queue_word(dtms_pkg::TOK_END_NODE);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) queue_word(dtms_pkg::TOK_END_NODE);
    queue_word(dtms_pkg::TOK_END);
    repeat ($urandom_range(0, 2)) queue_word($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      cut = $urandom_range(1, blk_words.size() - 1);
      while (blk_words.size() > cut) begin
        void'(blk_words.pop_back());
        void'(blk_firsts.pop_back());
      end
    end else if (roll < 16) begin
      blk_words[$urandom_range(1, blk_words.size() - 1)] = $urandom;
    end else if (roll < 22) begin
      repeat ($urandom_range(1, 8)) queue_word($urandom, 1'($urandom_range(0, 1)));
    end
  endfunction

  // Nesting past the depth limit, then closing more nodes than were opened.
  function automatic void gen_deep_block();
    blk_words.delete();
    blk_firsts.delete();
    queue_word(dtms_pkg::TOK_BEGIN_NODE, 1'b1);
    queue_word(32'h0);
    repeat (DEPTH_LIMIT + 3) begin
      queue_word(dtms_pkg::TOK_BEGIN_NODE);
      queue_word(32'h6400_0000);
    end
    queue_word(dtms_pkg::TOK_BEGIN_NODE);
    gen_name(1'b1);
    gen_pairs(1);
    repeat (DEPTH_LIMIT + 8) queue_word(dtms_pkg::TOK_END_NODE);
    queue_word(dtms_pkg::TOK_BEGIN_NODE);
    gen_name(1'b1);
    gen_pairs(2);
    queue_word(dtms_pkg::TOK_END_NODE);
    queue_word(dtms_pkg::TOK_END);
  endfunction

  task automatic send_block();
    foreach (blk_words[i]) send_word(blk_words[i], blk_firsts[i]);
  endtask

  function automatic void add_row(input row_op_t op, input logic [63:0] value,
                                  input logic first, input logic typed = 1'b0,
                                  input logic [1:0] kind = dtms_pkg::KIND_REGION,
                                  input logic [31:0] count = 32'h0);
    dir_row_t row;
    row.op    = op;
    row.value = value;
    row.first = first;
    row.typed = typed;
    row.kind  = kind;
    row.count = count;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stalls, pressure hold-off and checking.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual kind %0d base %h",
                 $time, out_kind, out_mem_base);
        $display("%0t: unexpected result continued, len %h count %h",
                 $time, out_mem_len, out_region_count);
      end else begin
        want = expected_reports.pop_front();
        check_field("kind", {62'h0, want.kind}, {62'h0, out_kind});
        check_field("mem_base", want.base, out_mem_base);
        check_field("mem_len", want.len, out_mem_len);
        check_field("region_count", {32'h0, want.count}, {32'h0, out_region_count});
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int queued;
    int phase;
    int goal;
    logic [63:0] new_kend;
    logic [31:0] new_size;
    report_t rep;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    in_first = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    kern_top_reg    = '0;
    struct_size_reg = '0;
    clear_walk();

    // With a zero size limit the first word already ends the walk.
    add_row(ROW_ITEM, dtms_pkg::TOK_BEGIN_NODE, 1'b1, 1'b1, dtms_pkg::KIND_NONE, 32'd0);
    add_row(ROW_ITEM, 32'hFFFF_FFFF, 1'b0);
    add_row(ROW_KEND, 64'h0000_0000_8000_0000, 1'b0);
    add_row(ROW_SIZE, 64'h0000_0000_FFFF_FFFF, 1'b0);
    // Root, then a node named "memory" holding three pairs.
    add_row(ROW_ITEM, dtms_pkg::TOK_BEGIN_NODE, 1'b1);
    add_row(ROW_ITEM, 32'h0, 1'b0);
    add_row(ROW_ITEM, dtms_pkg::TOK_BEGIN_NODE, 1'b0);
    add_row(ROW_ITEM, dtms_pkg::MEM_WORD0, 1'b0);
    add_row(ROW_ITEM, 32'h7279_0000, 1'b0);
    add_row(ROW_ITEM, dtms_pkg::TOK_PROP, 1'b0);
    add_row(ROW_ITEM, 32'd48, 1'b0);
    add_row(ROW_ITEM, 32'hFFFF_FFFF, 1'b0);
    // Pair straddling the kernel end: trimmed.
    add_row(ROW_ITEM, 32'h0, 1'b0);
    add_row(ROW_ITEM, 32'h4000_0000, 1'b0);
    add_row(ROW_ITEM, 32'h0, 1'b0);
    add_row(ROW_ITEM, 32'h8000_0000, 1'b0);
    // Pair at the top of the address space whose end wraps: passed whole.
    add_row(ROW_ITEM, 32'hFFFF_FFFF, 1'b0);
    add_row(ROW_ITEM, 32'hFFFF_F000, 1'b0);
    add_row(ROW_ITEM, 32'h0, 1'b0);
    add_row(ROW_ITEM, 32'h0000_2000, 1'b0);
    // Pair wholly below the kernel end: dropped but counted.
    add_row(ROW_ITEM, 32'h0, 1'b0);
    add_row(ROW_ITEM, 32'h0, 1'b0);
    add_row(ROW_ITEM, 32'h0, 1'b0);
    add_row(ROW_ITEM, 32'h0000_1000, 1'b0);
    add_row(ROW_ITEM, dtms_pkg::TOK_END_NODE, 1'b0);
    add_row(ROW_ITEM, dtms_pkg::TOK_END, 1'b0, 1'b1, dtms_pkg::KIND_DONE, 32'd3);
    // A fresh block that opens with an unknown token.
    add_row(ROW_ITEM, 32'h0000_0005, 1'b1, 1'b1, dtms_pkg::KIND_BADTOKEN, 32'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed list; typed rows stand in for the predicted report.
    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        ROW_KEND: begin
          settle();
          write_reg(REG_KTOP, dir_rows[i].value);
        end
        ROW_SIZE: begin
          settle();
          write_reg(REG_STRUCT_SIZE, dir_rows[i].value);
        end
        default: begin
          queued = expected_reports.size();
          send_word(dir_rows[i].value[31:0], dir_rows[i].first);
          if (dir_rows[i].typed) begin
            if (expected_reports.size() > queued) void'(expected_reports.pop_back());
            rep = {dir_rows[i].kind, 64'h0, 64'h0, dir_rows[i].count};
            expected_reports.push_back(rep);
          end
        end
      endcase
    end

    // Random blocks under a new register setting in each phase.
    for (phase = 0; phase < 6 || live_items < RANDOM_ITEMS; phase++) begin
      settle();
      case (phase)
        0: begin
          new_kend = 64'h0;
          new_size = 32'hFFFF_FFFF;
        end
        1: begin
          new_kend = '1;
          new_size = 32'hFFFF_FFFF;
        end
        2: begin
          new_kend = {$urandom, $urandom};
          new_size = $urandom_range(0, 160);
        end
        3: begin
          new_kend = {32'h0, $urandom};
          new_size = 32'hFFFF_FFFF;
        end
        default: begin
          new_kend = pick_addr();
          new_size = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 300);
        end
      endcase
      write_reg(REG_KTOP, new_kend);
      write_reg(REG_STRUCT_SIZE, {32'h0, new_size});
      // One phase runs with no idling at all.
      in_idle_pct  = (phase == 3) ? 0 : IDLE_PCT;
      out_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
      if (phase == 4) begin
        new_size = 32'hFFFF_FFFF;
        hold_ask = 1'b1;
      end
      goal = live_items + PHASE_ITEMS;
      while (live_items < goal) begin
        gen_block();
        send_block();
      end
      if (phase == 4) begin
        settle();
        write_reg(REG_STRUCT_SIZE, {32'h0, new_size});
        gen_deep_block();
        send_block();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
